// ===== src/mrt_pkg.sv =====
// Shared types, constants and helpers for the memory region table.
// No dependencies; every other file imports this package.
package mrt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KIND_W      = 8;
   localparam int ADDR_W      = 64;
   localparam int RIDX_W      = 5;

   // command codes
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [KIND_W-1:0] region_kind;
      logic [ADDR_W-1:0] region_base;
      logic [ADDR_W-1:0] region_length;
      logic [RIDX_W-1:0] read_index;
   } req_word_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [5:0]        first_index;
      logic [5:0]        match_count;
      logic [KIND_W-1:0] out_kind;
      logic [ADDR_W-1:0] out_base;
      logic [ADDR_W-1:0] out_length;
      logic [5:0]        held_count;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic eval;
      logic load;
   } mrt_cmd_type;

   // datapath and channels to controller
   typedef struct packed {
      logic req_valid;
      logic rsp_free;
   } mrt_stat_type;

   // count set bits of a cell flag vector
   function automatic logic [CNT_W-1:0] pop_count(logic [TABLE_DEPTH-1:0] v);
      logic [CNT_W-1:0] s;
      s = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         s = s + CNT_W'(v[i]);
      end
      return s;
   endfunction

endpackage

// ===== src/mrt_chan_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on mrt_pkg for the word types.
interface mrt_req_if;
   import mrt_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface mrt_rsp_if;
   import mrt_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

// ===== src/mrt_ctrl.sv =====
// Controller for the memory region table: sequences capture, evaluate, load.
// Depends on mrt_pkg for the command and status structs.
module mrt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  mrt_pkg::mrt_stat_type stat,
   output mrt_pkg::mrt_cmd_type  cmd,
   output logic                  req_ready
);
   import mrt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_TALLY
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   // decode commands from the current state
   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && stat.req_valid;
      cmd.eval    = (state_ff == ST_EVAL);
      cmd.load    = (state_ff == ST_TALLY) && stat.rsp_free;
   end

   assign req_ready = ready_ff;

   // advance state; hold in tally until the response register frees
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (stat.req_valid) begin
                  state_ff <= ST_EVAL;
                  ready_ff <= 1'b0;
               end
            end
            ST_EVAL: begin
               state_ff <= ST_TALLY;
            end
            ST_TALLY: begin
               if (stat.rsp_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

// ===== src/mrt_datapath.sv =====
// Datapath for the memory region table: sorted cell chain, compare flags,
// tally and response register. Depends on mrt_pkg.
module mrt_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  mrt_pkg::mrt_cmd_type  cmd,
   input  mrt_pkg::req_word_type req_word,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output mrt_pkg::rsp_word_type rsp_word,
   output logic                  rsp_free
);
   import mrt_pkg::*;

   req_word_type             req_ff;
   logic [KIND_W-1:0]        kind_ff   [TABLE_DEPTH];
   logic [ADDR_W-1:0]        base_ff   [TABLE_DEPTH];
   logic [ADDR_W-1:0]        length_ff [TABLE_DEPTH];
   logic [CNT_W-1:0]         count_ff;
   logic [TABLE_DEPTH-1:0]   eq_ff;
   logic [TABLE_DEPTH-1:0]   lt_ff;
   logic [1:0]               status_ff;
   logic [KIND_W-1:0]        rd_kind_ff;
   logic [ADDR_W-1:0]        rd_base_ff;
   logic [ADDR_W-1:0]        rd_length_ff;
   rsp_word_type             rsp_ff;
   logic                     rsp_valid_ff;

   logic [TABLE_DEPTH-1:0]   live;
   logic [TABLE_DEPTH-1:0]   le_vec;
   logic [TABLE_DEPTH-1:0]   eq_in;
   logic [TABLE_DEPTH-1:0]   lt_in;
   logic                     full;
   logic                     idx_bad;
   logic [CNT_W-1:0]         match_cnt;
   logic [CNT_W-1:0]         lt_cnt;
   rsp_word_type             rsp_in;

   // per-cell compares against the captured kind
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         live[i]   = CNT_W'(i) < count_ff;
         le_vec[i] = live[i] && (kind_ff[i] <= req_ff.region_kind);
         eq_in[i]  = live[i] && (kind_ff[i] == req_ff.region_kind);
         lt_in[i]  = live[i] && (kind_ff[i] <  req_ff.region_kind);
      end
   end

   assign full    = (count_ff == CNT_W'(TABLE_DEPTH));
   assign idx_bad = (CNT_W'(req_ff.read_index) >= count_ff);

   // capture the request word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_word;
      end
   end

   // shift the cell chain: cells past the insert point take their neighbor
   always_ff @(posedge clock) begin
      if (cmd.eval && (req_ff.cmd == CMD_APPEND) && !full) begin
         if (!le_vec[0]) begin
            kind_ff[0]   <= req_ff.region_kind;
            base_ff[0]   <= req_ff.region_base;
            length_ff[0] <= req_ff.region_length;
         end
         for (int i = 1; i < TABLE_DEPTH; i++) begin
            if (!le_vec[i]) begin
               if (le_vec[i-1]) begin
                  kind_ff[i]   <= req_ff.region_kind;
                  base_ff[i]   <= req_ff.region_base;
                  length_ff[i] <= req_ff.region_length;
               end else begin
                  kind_ff[i]   <= kind_ff[i-1];
                  base_ff[i]   <= base_ff[i-1];
                  length_ff[i] <= length_ff[i-1];
               end
            end
         end
      end
   end

   // update the held count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.eval) begin
         if (req_ff.cmd == CMD_CLEAR) begin
            count_ff <= '0;
         end else if ((req_ff.cmd == CMD_APPEND) && !full) begin
            count_ff <= CNT_W'(count_ff + 1'b1);
         end
      end
   end

   // register flags, status and the read entry
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         eq_ff        <= eq_in;
         lt_ff        <= lt_in;
         status_ff    <= STAT_OK;
         rd_kind_ff   <= '0;
         rd_base_ff   <= '0;
         rd_length_ff <= '0;
         case (req_ff.cmd)
            CMD_APPEND: begin
               if (full) begin
                  status_ff <= STAT_FULL;
               end
            end
            CMD_READ: begin
               if (idx_bad) begin
                  status_ff <= STAT_RANGE;
               end else begin
                  rd_kind_ff   <= kind_ff[req_ff.read_index];
                  rd_base_ff   <= base_ff[req_ff.read_index];
                  rd_length_ff <= length_ff[req_ff.read_index];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // tally the query run and build the response word
   assign match_cnt = pop_count(eq_ff);
   assign lt_cnt    = pop_count(lt_ff);

   always_comb begin
      rsp_in            = '0;
      rsp_in.status     = status_ff;
      rsp_in.held_count = 6'(count_ff);
      rsp_in.out_kind   = rd_kind_ff;
      rsp_in.out_base   = rd_base_ff;
      rsp_in.out_length = rd_length_ff;
      if (req_ff.cmd == CMD_QUERY) begin
         rsp_in.match_count = 6'(match_cnt);
         rsp_in.first_index = (match_cnt == '0) ? 6'(count_ff) : 6'(lt_cnt);
      end
   end

   // hold the response until taken
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // the held count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("held count beyond table depth");

   // an append into a non-full table grows the count by one
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && (req_ff.cmd == CMD_APPEND) && !full)
      |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("append did not grow the count");

   // a response is loaded only into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> rsp_free)
      else $error("response overwritten before taken");

   // a query run never extends past the held count
   a_run_inside: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && (req_ff.cmd == CMD_QUERY))
      |-> ((CNT_W'(rsp_in.first_index) + CNT_W'(rsp_in.match_count)) <= count_ff))
      else $error("query run beyond held count");

endmodule

// ===== src/memory_region_table_by_kind.sv =====
// Top level of the memory region table kept stably ordered by kind.
// Depends on mrt_pkg, mrt_chan_if, mrt_ctrl and mrt_datapath.
//
//   channel   direction  word           handshake
//   req_chan  in         req_word_type  valid/ready
//   rsp_chan  out        rsp_word_type  valid/ready
//
// Each word is captured at the accepting edge, evaluated in the cell chain, and then
// the tally step loads the popcount tally of the query flags into the response
// register, which drives it out as valid.
// A new word is taken once the previous one is loaded into the response register.
// A stalled response holds the controller in the tally step.
// Reset clears the held count; cell contents stay undefined until appended.
module memory_region_table_by_kind (
   input logic        clock,
   input logic        reset,
   mrt_req_if.sink    req_chan,
   mrt_rsp_if.source  rsp_chan
);
   import mrt_pkg::*;

   mrt_cmd_type  cmd;
   mrt_stat_type stat;
   logic         ready;
   logic         rsp_free;

   assign stat.req_valid = req_chan.valid;
   assign stat.rsp_free  = rsp_free;
   assign req_chan.ready = ready;

   mrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (ready)
   );

   mrt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_word  (req_chan.word),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_word  (rsp_chan.word),
      .rsp_free  (rsp_free)
   );

endmodule

// ===== test/region_table_checker.sv =====
// Checker for the memory region table: watches both channels, predicts each reply.
// Depends on mrt_pkg for word types and codes, and on mrt_chan_if for the channels.
// Reports the mismatch count and the number of replies still due to the test top.
module region_table_checker (
   input  logic clock,
   input  logic reset,
   mrt_req_if   req_chan,
   mrt_rsp_if   rsp_chan,
   output int   fail_count,
   output int   awaited
);
   timeunit 1ns;
   timeprecision 1ps;
   import mrt_pkg::*;

   // shadow copy of the region table
   logic [KIND_W-1:0] kinds   [TABLE_DEPTH];
   logic [ADDR_W-1:0] bases   [TABLE_DEPTH];
   logic [ADDR_W-1:0] lengths [TABLE_DEPTH];
   int                held = 0;
   int                mismatches = 0;
   rsp_word_type      replies_due [$];

   // apply one request word to the shadow table and return the reply it earns
   function automatic rsp_word_type apply_table_word(input req_word_type w);
      rsp_word_type r;
      int           pos;
      int           first;
      int           last;
      r = '0;
      case (w.cmd)
         CMD_CLEAR: begin
            held = 0;
         end
         CMD_APPEND: begin
            if (held >= TABLE_DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               // place after every region of the same or a lower kind
               pos = 0;
               while (pos < held && kinds[pos] <= w.region_kind) pos++;
               for (int k = held; k > pos; k--) begin
                  kinds[k]   = kinds[k-1];
                  bases[k]   = bases[k-1];
                  lengths[k] = lengths[k-1];
               end
               kinds[pos]   = w.region_kind;
               bases[pos]   = w.region_base;
               lengths[pos] = w.region_length;
               held++;
            end
         end
         CMD_QUERY: begin
            first = 0;
            while (first < held && kinds[first] != w.region_kind) first++;
            last = first;
            while (last < held && kinds[last] == w.region_kind) last++;
            r.first_index = 6'(first);
            r.match_count = 6'(last - first);
         end
         default: begin
            if (int'(w.read_index) >= held) begin
               r.status = STAT_RANGE;
            end else begin
               r.out_kind   = kinds[w.read_index];
               r.out_base   = bases[w.read_index];
               r.out_length = lengths[w.read_index];
            end
         end
      endcase
      r.held_count = 6'(held);
      return r;
   endfunction

   // compare replies first: a reply can never belong to a word taken at the same edge
   always @(posedge clock) begin : track
      rsp_word_type due;
      rsp_word_type got;
      if (reset) begin
         held = 0;
         replies_due.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.word;
            if (replies_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t reply word with nothing due: status %0d held %0d",
                           $realtime, got.status, got.held_count);
            end else begin
               due = replies_due.pop_front();
               if (got.status !== due.status || got.first_index !== due.first_index ||
                   got.match_count !== due.match_count || got.out_kind !== due.out_kind ||
                   got.out_base !== due.out_base || got.out_length !== due.out_length ||
                   got.held_count !== due.held_count) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("%0t reply mismatch (expected/actual): status %0d/%0d",
                            $realtime, due.status, got.status);
                     $write(" first %0d/%0d count %0d/%0d kind %h/%h",
                            due.first_index, got.first_index,
                            due.match_count, got.match_count,
                            due.out_kind, got.out_kind);
                     $display(" base %h/%h length %h/%h held %0d/%0d",
                              due.out_base, got.out_base,
                              due.out_length, got.out_length,
                              due.held_count, got.held_count);
                  end
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            replies_due.push_back(apply_table_word(req_chan.word));
      end
      fail_count <= mismatches;
      awaited    <= replies_due.size();
   end

endmodule

// ===== test/memory_region_table_by_kind_test.sv =====
// Test top for the memory region table: clock, reset, request and reply traffic, verdict.
// Depends on mrt_pkg, mrt_chan_if, the table RTL and region_table_checker.
module memory_region_table_by_kind_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mrt_pkg::*;

   localparam int WORD_GOAL   = 1150;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_AFTER  = 300;
   localparam int HOLD_OFF    = 250;
   localparam int SETTLE      = 12;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   int                fail_count;
   int                awaited;
   int                words_sent = 0;
   int                quiet_cycles = 0;
   bit                steady = 1'b0;
   logic [KIND_W-1:0] palette [6];

   mrt_req_if req_chan ();
   mrt_rsp_if rsp_chan ();

   memory_region_table_by_kind dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   region_table_checker table_check (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .fail_count (fail_count),
      .awaited    (awaited)
   );

   always #2 clock = ~clock;

   // mostly short gaps, a few long ones, none while calm
   function automatic int idle_gap(input bit calm);
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [ADDR_W-1:0] wide_random();
      return {$urandom, $urandom};
   endfunction

   function automatic req_word_type make_word(input logic [1:0] cmd,
                                              input logic [KIND_W-1:0] kind,
                                              input logic [ADDR_W-1:0] base,
                                              input logic [ADDR_W-1:0] len,
                                              input logic [RIDX_W-1:0] idx);
      req_word_type w;
      w.cmd           = cmd;
      w.region_kind   = kind;
      w.region_base   = base;
      w.region_length = len;
      w.read_index    = idx;
      return w;
   endfunction

   // offer one word after an optional gap; return at the edge that takes it
   task automatic send_word(input req_word_type w);
      int gap;
      gap = idle_gap(steady);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.word  <= w;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
   endtask

   // query a kind or read a position, biased toward the filled part of the table
   task automatic probe_table(input int span);
      logic [KIND_W-1:0] kind;
      logic [RIDX_W-1:0] idx;
      kind = ($urandom_range(0, 9) < 7) ? palette[$urandom_range(0, 5)] : KIND_W'($urandom);
      idx  = ($urandom_range(0, 9) < 8) ? RIDX_W'($urandom_range(0, span))
                                        : RIDX_W'($urandom);
      send_word(make_word(($urandom_range(0, 1) != 0) ? CMD_QUERY : CMD_READ,
                          kind, wide_random(), wide_random(), idx));
   endtask

   // clear, fill from a small set of kinds so runs form, then probe
   task automatic fill_sequence();
      int fills;
      int placed;
      steady = ($urandom_range(0, 4) == 0);
      foreach (palette[i]) palette[i] = KIND_W'($urandom);
      if ($urandom_range(0, 2) == 0) palette[0] = '0;
      if ($urandom_range(0, 2) == 0) palette[5] = '1;
      send_word(make_word(CMD_CLEAR, KIND_W'($urandom), wide_random(), wide_random(),
                          RIDX_W'($urandom)));
      fills  = ($urandom_range(0, 3) == 0) ? $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 6)
                                           : $urandom_range(1, 20);
      placed = 0;
      repeat (fills) begin
         send_word(make_word(CMD_APPEND, palette[$urandom_range(0, 5)], wide_random(),
                             wide_random(), RIDX_W'($urandom)));
         placed++;
         if ($urandom_range(0, 3) == 0) probe_table(placed);
      end
      repeat ($urandom_range(2, 8)) probe_table(placed);
   endtask

   // unstructured words, clears included
   task automatic noise_burst();
      steady = 1'b0;
      repeat ($urandom_range(3, 12))
         send_word(make_word(2'($urandom), KIND_W'($urandom), wide_random(), wide_random(),
                             RIDX_W'($urandom)));
   endtask

   initial begin : stimulus
      req_chan.valid <= 1'b0;
      req_chan.word  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty table: read out of range, query with no match
      send_word(make_word(CMD_READ, '0, '0, '0, '0));
      send_word(make_word(CMD_QUERY, '0, '0, '0, '0));
      // appends at the kind extremes, a repeated kind to check arrival order
      send_word(make_word(CMD_APPEND, 8'h80, 64'h1000, 64'h100, '0));
      send_word(make_word(CMD_APPEND, '0, '0, '0, '1));
      send_word(make_word(CMD_APPEND, '1, '1, '1, '0));
      send_word(make_word(CMD_APPEND, 8'h80, 64'h8000_0000_0000_0000, 64'h1, '1));
      send_word(make_word(CMD_APPEND, 8'h01, 64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA,
                          5'h15));
      send_word(make_word(CMD_QUERY, 8'h80, '1, '1, '1));
      send_word(make_word(CMD_QUERY, '1, '0, '0, '0));
      send_word(make_word(CMD_QUERY, 8'h7F, '0, '0, '0));
      send_word(make_word(CMD_QUERY, '0, '0, '0, '0));
      for (int i = 0; i < 5; i++)
         send_word(make_word(CMD_READ, '1, '1, '1, RIDX_W'(i)));
      send_word(make_word(CMD_READ, '0, '0, '0, 5'd5));
      send_word(make_word(CMD_READ, '0, '0, '0, '1));
      // clear keeps stale entries out of reach
      send_word(make_word(CMD_CLEAR, '1, '1, '1, '1));
      send_word(make_word(CMD_READ, '0, '0, '0, '0));
      send_word(make_word(CMD_QUERY, 8'h80, '0, '0, '0));
      send_word(make_word(CMD_APPEND, 8'h55, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                          5'h0A));
      send_word(make_word(CMD_READ, '0, '0, '0, '0));

      while (words_sent < WORD_GOAL) begin
         if ($urandom_range(0, 3) != 0) fill_sequence();
         else noise_burst();
      end
      req_chan.valid <= 1'b0;

      // drain outstanding replies, then let the pipeline settle
      do @(posedge clock); while (awaited != 0);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // reply side: random stalls, calm stretches, and one long hold-off
   initial begin : drain_side
      int stall_left;
      int calm_left;
      int drained;
      bit held_off;
      stall_left = 0;
      calm_left  = 0;
      drained    = 0;
      held_off   = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) drained++;
         if (!held_off && drained >= HOLD_AFTER) begin
            held_off   = 1'b1;
            stall_left = HOLD_OFF;
            calm_left  = 0;
         end else if (calm_left == 0 && stall_left == 0 && $urandom_range(0, 59) == 0) begin
            calm_left = $urandom_range(40, 120);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_chan.ready <= 1'b1;
         end else begin
            stall_left = idle_gap(1'b0);
            rsp_chan.ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // end the run when no word moves on either channel for too long
   always @(posedge clock) begin : watchdog
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== filelist.f =====
src/mrt_pkg.sv
src/mrt_chan_if.sv
src/mrt_ctrl.sv
src/mrt_datapath.sv
src/memory_region_table_by_kind.sv
test/region_table_checker.sv
test/memory_region_table_by_kind_test.sv
